FILE: rtl/config_record_check_unit_macros.svh
// Assertion macros shared by the config record checker RTL.
// Each macro expects clk_i and rst_ni to be visible at the place of use.
`ifndef CONFIG_RECORD_CHECK_UNIT_MACROS_SVH
`define CONFIG_RECORD_CHECK_UNIT_MACROS_SVH

// Clocked check, skipped while reset is asserted.
`define CRC_CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CRC_CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/crc_chk_pkg.sv
// Shared types and constants for the config record checker.
// No dependencies; used by the interfaces, the CRC step and the top level.
package crc_chk_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [WordW-1:0] CrcInit         = 16'hFFFF;
  localparam logic [WordW-1:0] ExpVersionReset = 16'd1;
  localparam logic [WordW-1:0] MaxLenReset     = 16'd4090;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegExpVersion = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxLength  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_VERSION = 2'd1,
    STATUS_CRC     = 2'd2
  } status_e;

  // CRC-16/MODBUS nibble table, reflected polynomial 0xA001.
  localparam logic [WordW-1:0] NibbleTable [16] = '{
    16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
    16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
  };

endpackage

FILE: rtl/crc_chk_if.sv
// Valid/ready channel interfaces for record bytes in and check results out.
// Depends on crc_chk_pkg for field widths.
interface crc_chk_in_if;
  logic                             valid;
  logic                             ready;
  logic [crc_chk_pkg::ByteW-1:0]    record_byte;
  logic                             record_start;

  modport source (output valid, record_byte, record_start, input ready);
  modport sink   (input valid, record_byte, record_start, output ready);
endinterface

interface crc_chk_out_if;
  logic                             valid;
  logic                             ready;
  logic [crc_chk_pkg::StatusW-1:0]  check_status;
  logic [crc_chk_pkg::WordW-1:0]    payload_length;
  logic [crc_chk_pkg::WordW-1:0]    computed_crc;
  logic [crc_chk_pkg::WordW-1:0]    stored_crc;

  modport source (output valid, check_status, payload_length, computed_crc, stored_crc,
                  input ready);
  modport sink   (input valid, check_status, payload_length, computed_crc, stored_crc,
                  output ready);
endinterface

FILE: rtl/crc_chk_crc_byte.sv
// One byte of CRC-16/MODBUS as two nibble table steps, low nibble first.
// Depends on crc_chk_pkg for the nibble table.
module crc_chk_crc_byte (
  input  logic [crc_chk_pkg::WordW-1:0] crc_i,
  input  logic [crc_chk_pkg::ByteW-1:0] data_i,
  output logic [crc_chk_pkg::WordW-1:0] crc_o
);

  logic [crc_chk_pkg::WordW-1:0] crc_lo;

  assign crc_lo = crc_chk_pkg::NibbleTable[data_i[3:0] ^ crc_i[3:0]] ^ (crc_i >> 4);
  assign crc_o  = crc_chk_pkg::NibbleTable[data_i[7:4] ^ crc_lo[3:0]] ^ (crc_lo >> 4);

endmodule

FILE: rtl/config_record_check_unit.sv
// Config record checker: takes one record byte per transfer and parses the 6-byte header
// (version, length, stored CRC), then runs CRC-16/MODBUS over the payload, at most one
// byte per clock. A result comes out of the result register in the cycle after the byte that
// ends the record: header byte 1 on a version mismatch, header byte 5 for an empty payload,
// otherwise the last payload byte. Input ready drops only while a result waits untaken.
// Depends on crc_chk_pkg, crc_chk_if.sv, crc_chk_crc_byte and the assertion macros.
`include "config_record_check_unit_macros.svh"

module config_record_check_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crc_chk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [crc_chk_pkg::WordW-1:0]     cfg_data_i,
  crc_chk_in_if.sink                        rec_i,
  crc_chk_out_if.source                     res_o
);

  localparam int unsigned W = crc_chk_pkg::WordW;

  localparam logic [2:0] HdrVerHi = 3'd0;
  localparam logic [2:0] HdrVerLo = 3'd1;
  localparam logic [2:0] HdrLenHi = 3'd2;
  localparam logic [2:0] HdrLenLo = 3'd3;
  localparam logic [2:0] HdrCrcHi = 3'd4;

  // Configuration registers
  logic [W-1:0] exp_ver_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= crc_chk_pkg::ExpVersionReset;
      max_len_q <= crc_chk_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crc_chk_pkg::RegExpVersion: exp_ver_q <= cfg_data_i;
        crc_chk_pkg::RegMaxLength:  max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Record state
  logic [W-1:0] pos_q, ver_q, len_q, crch_q, crc_q;
  logic         done_q, inp_q;
  logic [W-1:0] pos_d, ver_d, len_d, crch_d, crc_d;
  logic         done_d, inp_d;

  // Current view of the state, with a record start taking effect on its own byte
  logic [W-1:0] pos_c, ver_c, len_c, crch_c, crc_c;
  logic         done_c, inp_c;
  logic [W-1:0] crc_upd;
  logic [W-1:0] ver_full, len_full;

  // Result
  logic                  emit;
  crc_chk_pkg::status_e  status_d;
  logic [W-1:0]          len_out_d, crc_out_d, crch_out_d;

  logic in_fire;
  logic res_valid_q;
  logic [crc_chk_pkg::StatusW-1:0] status_q;
  logic [W-1:0] len_out_q, crc_out_q, crch_out_q;

  assign rec_i.ready = !res_valid_q || res_o.ready;
  assign in_fire     = rec_i.valid && rec_i.ready;

  crc_chk_crc_byte u_crc_byte (
    .crc_i  (crc_c),
    .data_i (rec_i.record_byte),
    .crc_o  (crc_upd)
  );

  always_comb begin
    pos_c  = rec_i.record_start ? '0 : pos_q;
    ver_c  = rec_i.record_start ? '0 : ver_q;
    len_c  = rec_i.record_start ? '0 : len_q;
    crch_c = rec_i.record_start ? '0 : crch_q;
    crc_c  = rec_i.record_start ? crc_chk_pkg::CrcInit : crc_q;
    done_c = rec_i.record_start ? 1'b0 : done_q;
    inp_c  = rec_i.record_start ? 1'b0 : inp_q;

    ver_full = {ver_c[W-1:crc_chk_pkg::ByteW], rec_i.record_byte};
    len_full = {len_c[W-1:crc_chk_pkg::ByteW], rec_i.record_byte};

    pos_d  = pos_c;
    ver_d  = ver_c;
    len_d  = len_c;
    crch_d = crch_c;
    crc_d  = crc_c;
    done_d = done_c;
    inp_d  = inp_c;

    emit       = 1'b0;
    status_d   = crc_chk_pkg::STATUS_OK;
    len_out_d  = len_c;
    crc_out_d  = crc_c;
    crch_out_d = crch_c;

    if (!done_c) begin
      if (inp_c) begin
        crc_d = crc_upd;
        pos_d = pos_c + W'(1);
        if (pos_d >= len_c) begin
          emit      = 1'b1;
          done_d    = 1'b1;
          crc_out_d = crc_upd;
          status_d  = (crc_upd == crch_c) ? crc_chk_pkg::STATUS_OK : crc_chk_pkg::STATUS_CRC;
        end
      end else begin
        pos_d = pos_c + W'(1);
        case (pos_c[2:0])
          HdrVerHi: ver_d = {rec_i.record_byte, crc_chk_pkg::ByteW'(0)};
          HdrVerLo: begin
            ver_d = ver_full;
            if (ver_full != exp_ver_q) begin
              emit       = 1'b1;
              done_d     = 1'b1;
              status_d   = crc_chk_pkg::STATUS_VERSION;
              len_out_d  = '0;
              crc_out_d  = '0;
              crch_out_d = '0;
            end
          end
          HdrLenHi: len_d = {rec_i.record_byte, crc_chk_pkg::ByteW'(0)};
          // clamp to the configured maximum as the low length byte lands
          HdrLenLo: len_d = (len_full > max_len_q) ? max_len_q : len_full;
          HdrCrcHi: crch_d = {rec_i.record_byte, crc_chk_pkg::ByteW'(0)};
          default: begin
            crch_d = {crch_c[W-1:crc_chk_pkg::ByteW], rec_i.record_byte};
            inp_d  = 1'b1;
            pos_d  = '0;
            if (len_c == '0) begin
              emit       = 1'b1;
              done_d     = 1'b1;
              crch_out_d = crch_d;
              status_d   = (crc_c == crch_d) ? crc_chk_pkg::STATUS_OK
                                             : crc_chk_pkg::STATUS_CRC;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ver_q  <= '0;
      len_q  <= '0;
      crch_q <= '0;
      crc_q  <= crc_chk_pkg::CrcInit;
      done_q <= 1'b1;
      inp_q  <= 1'b0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      ver_q  <= ver_d;
      len_q  <= len_d;
      crch_q <= crch_d;
      crc_q  <= crc_d;
      done_q <= done_d;
      inp_q  <= inp_d;
    end
  end

  // Result register: load on a transfer that ends a record, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_fire) begin
      res_valid_q <= emit;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      status_q   <= status_d;
      len_out_q  <= len_out_d;
      crc_out_q  <= crc_out_d;
      crch_out_q <= crch_out_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.check_status   = status_q;
  assign res_o.payload_length = len_out_q;
  assign res_o.computed_crc   = crc_out_q;
  assign res_o.stored_crc     = crch_out_q;

  `CRC_CHK_ASSERT(a_emit_goes_idle, (in_fire && emit) |=> done_q,
                  "record still active after its result")
  `CRC_CHK_ASSERT(a_version_zero_fields,
                  (res_valid_q && status_q == crc_chk_pkg::STATUS_VERSION) |->
                  (len_out_q == '0 && crc_out_q == '0 && crch_out_q == '0),
                  "version mismatch result carries nonzero fields")
  `CRC_CHK_ASSERT(a_ok_means_match,
                  (res_valid_q && status_q == crc_chk_pkg::STATUS_OK) |->
                  (crc_out_q == crch_out_q),
                  "pass result with differing CRCs")
  `CRC_CHK_ASSERT_ALWAYS(a_header_pos_range, (!done_q && !inp_q) |-> (pos_q <= W'(5)),
                         "header byte position out of range")

endmodule
